// ===== rtl/dspd_pkg.sv =====
// package: shared types and constants for the dual-side pd drive controller
`default_nettype none
package dspd_pkg;
  localparam int unsigned ErrW = 33;
  localparam int unsigned PdW = 53;
  localparam int unsigned PwrW = 16;
  localparam int unsigned DivSteps = 15;

  localparam logic [2:0] RegTargetLeft = 3'd0;
  localparam logic [2:0] RegTargetRight = 3'd1;
  localparam logic [2:0] RegKpGain = 3'd2;
  localparam logic [2:0] RegKdGain = 3'd3;
  localparam logic [2:0] RegRampStep = 3'd4;
  localparam logic [2:0] RegMaxPower = 3'd5;
  localparam logic [2:0] RegLeftTrim = 3'd6;
  localparam logic [2:0] RegSettleBand = 3'd7;

  typedef struct packed {
    logic [31:0] enc_left;
    logic [31:0] enc_right;
  } in_word_t;

  typedef struct packed {
    logic [15:0] drive_left;
    logic [15:0] drive_right;
    logic        settled;
  } out_word_t;

  typedef struct packed {
    logic [31:0] target_left;
    logic [31:0] target_right;
    logic [15:0] kp_gain;
    logic [15:0] kd_gain;
    logic [14:0] ramp_step;
    logic [14:0] max_power;
    logic [15:0] left_trim;
    logic [15:0] settle_band;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic mul_p;
    logic mul_d;
    logic sum;
    logic pick;
    logic div_step;
    logic goal;
    logic slew;
    logic trim;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } sts_t;
endpackage
`default_nettype wire

// ===== rtl/dspd_if.sv =====
// interfaces: valid/ready stream channel and configuration write channel
`default_nettype none
interface dspd_in_if;
  import dspd_pkg::*;
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dspd_out_if;
  import dspd_pkg::*;
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dspd_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/dual_side_pd_drive_controller_unit.sv =====
// top level: dual-side pd drive controller
// One word is taken at a time and its result is shown after the accepting
// edge has gone through the p and d multiply, sum and pick states, the
// bit-serial ratio divider (15 steps and a done state), then the goal,
// slew and trim states; the result is held until taken, and the next word
// can be accepted in the cycle after the result is taken.
`default_nettype none
module dual_side_pd_drive_controller_unit
  import dspd_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  dspd_in_if.sink   in_ch,
  dspd_out_if.source out_ch,
  dspd_cfg_if.sink  cfg_ch
);
  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  dspd_regs u_regs (.clk_i, .rst_ni, .cfg(cfg_ch), .cfg_o(cfg));

  dspd_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_ch.valid), .in_ready_o(in_ch.ready),
    .out_valid_o(out_ch.valid), .out_ready_i(out_ch.ready),
    .cmd_o(cmd), .sts_i(sts)
  );

  dspd_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .in_i(in_ch.data), .cfg_i(cfg), .res_o(out_ch.data)
  );
endmodule
`default_nettype wire

// ===== rtl/dspd_regs.sv =====
// configuration register file
`default_nettype none
module dspd_regs
  import dspd_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  dspd_cfg_if.sink    cfg,
  output cfg_t        cfg_o
);
  cfg_t cfg_q;

  assign cfg.ready = 1'b1;
  assign cfg_o = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_left <= '0;
      cfg_q.target_right <= '0;
      cfg_q.kp_gain <= 16'd59;
      cfg_q.kd_gain <= 16'd2560;
      cfg_q.ramp_step <= 15'd512;
      cfg_q.max_power <= 15'd25600;
      cfg_q.left_trim <= 16'd65470;
      cfg_q.settle_band <= 16'd8;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        RegTargetLeft: cfg_q.target_left <= cfg.data;
        RegTargetRight: cfg_q.target_right <= cfg.data;
        RegKpGain: cfg_q.kp_gain <= cfg.data[15:0];
        RegKdGain: cfg_q.kd_gain <= cfg.data[15:0];
        RegRampStep: cfg_q.ramp_step <= cfg.data[14:0];
        RegMaxPower: cfg_q.max_power <= cfg.data[14:0];
        RegLeftTrim: cfg_q.left_trim <= cfg.data[15:0];
        RegSettleBand: cfg_q.settle_band <= cfg.data[15:0];
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== rtl/dspd_datapath.sv =====
// datapath: errors, pd terms, ratio divider, slew and trim
`default_nettype none
module dspd_datapath
  import dspd_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  cmd_t      cmd_i,
  output sts_t      sts_o,
  input  in_word_t  in_i,
  input  cfg_t      cfg_i,
  output out_word_t res_o
);
  logic signed [ErrW-1:0] el_q, er_q, lel_q, ler_q;
  logic signed [ErrW:0]   dl_q, dr_q;
  logic signed [PdW-1:0]  pl_q, pr_q, ql_q, qr_q, pdl_q, pdr_q;
  logic [PdW-1:0] rem_q, num_q, den_q;
  logic [14:0] s_q, q_q;
  logic [3:0] cnt_q;
  logic ldom_q, keep_q, stl_q;
  logic signed [PwrW-1:0] gl_q, gr_q, al_q, ar_q;
  logic [PdW-1:0] ml_d, mr_d, big_d, r1, r2;
  logic [PdW:0] t1;
  logic q1, q2;
  logic signed [PwrW-1:0] gl_d, gr_d, sl_d, sr_d;
  logic [PwrW-1:0] amag;
  logic [31:0] tprod;
  logic [ErrW-1:0] mel, mer;

  function automatic logic signed [PwrW-1:0] slew_f(logic signed [PwrW-1:0] a,
      logic signed [PwrW-1:0] g, logic [14:0] lim);
    logic signed [PwrW:0] d;
    logic signed [PwrW:0] l;
    d = {g[PwrW-1], g} - {a[PwrW-1], a};
    l = {2'b00, lim};
    if (d > l) d = l;
    else if (d < -l) d = -l;
    return a + d[PwrW-1:0];
  endfunction

  always_comb begin
    ml_d = pdl_q[PdW-1] ? PdW'(-pdl_q) : PdW'(pdl_q);
    mr_d = pdr_q[PdW-1] ? PdW'(-pdr_q) : PdW'(pdr_q);
    big_d = (ml_d > mr_d) ? ml_d : mr_d;
    // two restoring steps per cycle: shift, then add numerator on set bit
    r1 = {rem_q[PdW-2:0], 1'b0};
    q1 = (r1 >= den_q);
    if (q1) r1 = r1 - den_q;
    t1 = {1'b0, r1} + (s_q[14] ? {1'b0, num_q} : '0);
    q2 = (t1 >= {1'b0, den_q});
    r2 = q2 ? PdW'(t1 - {1'b0, den_q}) : t1[PdW-1:0];
    gl_d = gl_q;
    gr_d = gr_q;
    if (!keep_q) begin
      if (ldom_q) begin
        gl_d = (pdl_q == 0) ? '0 : (pdl_q[PdW-1] ? -$signed({1'b0, s_q}) : $signed({1'b0, s_q}));
        gr_d = (pdr_q == 0) ? '0 : (pdr_q[PdW-1] ? -$signed({1'b0, q_q}) : $signed({1'b0, q_q}));
      end else begin
        gr_d = pdr_q[PdW-1] ? -$signed({1'b0, s_q}) : $signed({1'b0, s_q});
        gl_d = (pdl_q == 0) ? '0 : (pdl_q[PdW-1] ? -$signed({1'b0, q_q}) : $signed({1'b0, q_q}));
      end
    end
    sl_d = slew_f(al_q, gl_q, cfg_i.ramp_step);
    sr_d = slew_f(ar_q, gr_q, cfg_i.ramp_step);
    amag = al_q[PwrW-1] ? -al_q : al_q;
    tprod = amag * cfg_i.left_trim;
    mel = el_q[ErrW-1] ? -el_q : el_q;
    mer = er_q[ErrW-1] ? -er_q : er_q;
  end

  assign sts_o.div_done = (cnt_q == 4'd0);
  assign res_o.drive_left = al_q;
  assign res_o.drive_right = ar_q;
  assign res_o.settled = stl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      el_q <= '0;
      er_q <= '0;
      lel_q <= '0;
      ler_q <= '0;
      dl_q <= '0;
      dr_q <= '0;
      pl_q <= '0;
      pr_q <= '0;
      ql_q <= '0;
      qr_q <= '0;
      pdl_q <= '0;
      pdr_q <= '0;
      rem_q <= '0;
      num_q <= '0;
      den_q <= '0;
      s_q <= '0;
      q_q <= '0;
      ldom_q <= 1'b0;
      keep_q <= 1'b0;
      stl_q <= 1'b0;
      gl_q <= '0;
      gr_q <= '0;
      al_q <= '0;
      ar_q <= '0;
      cnt_q <= '0;
    end else begin
      if (cmd_i.load) begin
        el_q <= {cfg_i.target_left[31], cfg_i.target_left} - {in_i.enc_left[31], in_i.enc_left};
        er_q <= {cfg_i.target_right[31], cfg_i.target_right}
              - {in_i.enc_right[31], in_i.enc_right};
      end
      if (cmd_i.mul_p) begin
        pl_q <= PdW'(el_q * $signed({1'b0, cfg_i.kp_gain}));
        pr_q <= PdW'(er_q * $signed({1'b0, cfg_i.kp_gain}));
        dl_q <= {el_q[ErrW-1], el_q} - {lel_q[ErrW-1], lel_q};
        dr_q <= {er_q[ErrW-1], er_q} - {ler_q[ErrW-1], ler_q};
        lel_q <= el_q;
        ler_q <= er_q;
        stl_q <= (mel <= {17'd0, cfg_i.settle_band}) && (mer <= {17'd0, cfg_i.settle_band});
      end
      if (cmd_i.mul_d) begin
        ql_q <= PdW'(dl_q * $signed({1'b0, cfg_i.kd_gain}));
        qr_q <= PdW'(dr_q * $signed({1'b0, cfg_i.kd_gain}));
      end
      if (cmd_i.sum) begin
        pdl_q <= pl_q + ql_q;
        pdr_q <= pr_q + qr_q;
      end
      if (cmd_i.pick) begin
        ldom_q <= (ml_d >= mr_d);
        keep_q <= (pdl_q == 0) && (pdr_q != 0);
        s_q <= (big_d < {38'd0, cfg_i.max_power}) ? big_d[14:0] : cfg_i.max_power;
        num_q <= (ml_d >= mr_d) ? mr_d : ml_d;
        den_q <= (ml_d >= mr_d) ? ml_d : mr_d;
        rem_q <= '0;
        q_q <= '0;
        cnt_q <= 4'(DivSteps);
      end
      if (cmd_i.div_step && cnt_q != 0) begin
        // one quotient digit (0 to 2) per cycle; a zero divisor leaves quotient unused
        rem_q <= (den_q == 0) ? '0 : r2;
        q_q <= {q_q[13:0], 1'b0} + 15'(q1) + 15'(q2);
        s_q <= {s_q[13:0], s_q[14]};
        cnt_q <= cnt_q - 4'd1;
      end
      if (cmd_i.goal) begin
        gl_q <= gl_d;
        gr_q <= gr_d;
      end
      if (cmd_i.slew) begin
        al_q <= sl_d;
        ar_q <= sr_d;
      end
      if (cmd_i.trim) begin
        al_q <= al_q[PwrW-1] ? -$signed(tprod[31:16]) : $signed(tprod[31:16]);
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/dspd_ctrl.sv =====
// controller: sequences one word through the datapath
`default_nettype none
module dspd_ctrl
  import dspd_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output cmd_t      cmd_o,
  input  sts_t      sts_i
);
  typedef enum logic [3:0] {
    StIdle, StMulP, StMulD, StSum, StPick, StDiv, StGoal, StSlew, StTrim, StOut
  } state_e;
  state_e state_q;

  assign in_ready_o = (state_q == StIdle);
  assign out_valid_o = (state_q == StOut);

  always_comb begin
    cmd_o = '0;
    cmd_o.load = (state_q == StIdle) && in_valid_i;
    cmd_o.mul_p = (state_q == StMulP);
    cmd_o.mul_d = (state_q == StMulD);
    cmd_o.sum = (state_q == StSum);
    cmd_o.pick = (state_q == StPick);
    cmd_o.div_step = (state_q == StDiv);
    cmd_o.goal = (state_q == StGoal);
    cmd_o.slew = (state_q == StSlew);
    cmd_o.trim = (state_q == StTrim);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      unique case (state_q)
        StIdle: if (in_valid_i) state_q <= StMulP;
        StMulP: state_q <= StMulD;
        StMulD: state_q <= StSum;
        StSum: state_q <= StPick;
        StPick: state_q <= StDiv;
        StDiv: if (sts_i.div_done) state_q <= StGoal;
        StGoal: state_q <= StSlew;
        StSlew: state_q <= StTrim;
        StTrim: state_q <= StOut;
        StOut: if (out_ready_i) state_q <= StIdle;
        default: state_q <= StIdle;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== rtl/dspd_checker.sv =====
// checker: port-level properties of the controller
`default_nettype none
module dspd_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_i,
  input wire logic out_valid_i,
  input wire logic out_ready_i
);
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_i && out_valid_i)) else $error("input ready while result pending");
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i && !out_valid_i)
    else $error("not busy after accept");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i) else $error("result dropped");
  a_ready_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i |=> in_ready_i) else $error("not ready after take");
endmodule

bind dual_side_pd_drive_controller_unit dspd_checker u_chk (
  .clk_i, .rst_ni,
  .in_valid_i(in_ch.valid), .in_ready_i(in_ch.ready),
  .out_valid_i(out_ch.valid), .out_ready_i(out_ch.ready)
);
`default_nettype wire
